// ----- sv/socks5p_pkg.sv -----
// Shared types and constants for the SOCKS5 CONNECT request parser.
`default_nettype none
package socks5p_pkg;

  localparam logic [7:0] VER_SOCKS5  = 8'h05;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] TYPE_IPV4   = 8'h01;
  localparam logic [7:0] TYPE_NAME   = 8'h03;
  localparam logic [7:0] TYPE_IPV6   = 8'h04;
  localparam logic [7:0] IPV4_BYTES  = 8'd4;
  localparam logic [7:0] IPV6_BYTES  = 8'd16;
  localparam logic [7:0] IPV6_HALF   = 8'd8;

  typedef enum logic [1:0] {
    ST_MORE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_IP     = 2'd2,
    ST_NAME   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_IPV4 = 2'd0,
    KIND_IPV6 = 2'd1,
    KIND_NAME = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_VER   = 4'd0,
    PH_CMD   = 4'd1,
    PH_RSV   = 4'd2,
    PH_TYPE  = 4'd3,
    PH_IPV4  = 4'd4,
    PH_IPV6  = 4'd5,
    PH_NLEN  = 4'd6,
    PH_NAME  = 4'd7,
    PH_PORTH = 4'd8,
    PH_PORTL = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  bytes_left;
    logic [1:0]  kind;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  port_high_byte;
    logic [15:0] port_value;
    logic [7:0]  name_len;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_VER,
    bytes_left:     8'd0,
    kind:           2'd0,
    addr_hi:        64'd0,
    addr_lo:        64'd0,
    port_high_byte: 8'd0,
    port_value:     16'd0,
    name_len:       8'd0
  };

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  addr_kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] dst_port;
    logic [7:0]  name_length;
    logic        name_valid;
    logic [7:0]  name_byte;
    logic [7:0]  name_index;
  } parse_result_t;

endpackage
`default_nettype wire

// ----- sv/socks5p_if.sv -----
// Valid/ready channel interfaces for request words and parse results.
`default_nettype none
interface socks5p_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface socks5p_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  addr_kind;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] dst_port;
  logic [7:0]  name_length;
  logic        name_valid;
  logic [7:0]  name_byte;
  logic [7:0]  name_index;

  modport source (output valid, output status, output addr_kind, output addr_high,
                  output addr_low, output dst_port, output name_length,
                  output name_valid, output name_byte, output name_index, input ready);
  modport sink   (input valid, input status, input addr_kind, input addr_high,
                  input addr_low, input dst_port, input name_length,
                  input name_valid, input name_byte, input name_index, output ready);
endinterface
`default_nettype wire

// ----- sv/socks5p_step.sv -----
// Next-state and result logic for one request word.
`default_nettype none
module socks5p_step
  import socks5p_pkg::*;
(
  input  parse_state_t  state,
  input  logic          mode,
  input  logic [7:0]    data_byte,
  output parse_state_t  state_next,
  output parse_result_t result
);

  logic [1:0] status;
  logic       nvalid;
  logic [7:0] nindex;
  logic       last_byte;
  logic [7:0] left_dec;
  logic [7:0] v6_idx;

  always_comb begin
    last_byte = (state.bytes_left <= 8'd1);
    left_dec  = last_byte ? 8'd0 : state.bytes_left - 8'd1;
    v6_idx    = IPV6_BYTES - state.bytes_left;
  end

  always_comb begin
    state_next = state;
    status     = ST_MORE;
    nvalid     = 1'b0;
    nindex     = 8'd0;
    if (mode) begin
      state_next = STATE_RESET;
    end else begin
      unique case (state.phase)
        PH_VER: begin
          if (data_byte != VER_SOCKS5) status = ST_REJECT;
          else state_next.phase = PH_CMD;
        end
        PH_CMD: begin
          if (data_byte != CMD_CONNECT) status = ST_REJECT;
          else state_next.phase = PH_RSV;
        end
        PH_RSV: begin
          if (data_byte != 8'd0) status = ST_REJECT;
          else state_next.phase = PH_TYPE;
        end
        PH_TYPE: begin
          priority if (data_byte == TYPE_IPV4) begin
            state_next.kind       = KIND_IPV4;
            state_next.bytes_left = IPV4_BYTES;
            state_next.addr_hi    = 64'd0;
            state_next.addr_lo    = 64'd0;
            state_next.phase      = PH_IPV4;
          end else if (data_byte == TYPE_IPV6) begin
            state_next.kind       = KIND_IPV6;
            state_next.bytes_left = IPV6_BYTES;
            state_next.addr_hi    = 64'd0;
            state_next.addr_lo    = 64'd0;
            state_next.phase      = PH_IPV6;
          end else if (data_byte == TYPE_NAME) begin
            state_next.kind  = KIND_NAME;
            state_next.phase = PH_NLEN;
          end else begin
            status = ST_REJECT;
          end
        end
        PH_IPV4: begin
          state_next.addr_lo    = {32'd0, state.addr_lo[23:0], data_byte};
          state_next.bytes_left = left_dec;
          if (last_byte) state_next.phase = PH_PORTH;
        end
        PH_IPV6: begin
          if (v6_idx < IPV6_HALF) state_next.addr_hi = {state.addr_hi[55:0], data_byte};
          else state_next.addr_lo = {state.addr_lo[55:0], data_byte};
          state_next.bytes_left = left_dec;
          if (last_byte) state_next.phase = PH_PORTH;
        end
        PH_NLEN: begin
          if (data_byte == 8'd0) begin
            status = ST_REJECT;
          end else begin
            state_next.name_len   = data_byte;
            state_next.bytes_left = data_byte;
            state_next.phase      = PH_NAME;
          end
        end
        PH_NAME: begin
          nvalid                = 1'b1;
          nindex                = state.name_len - state.bytes_left;
          state_next.bytes_left = left_dec;
          if (last_byte) state_next.phase = PH_PORTH;
        end
        PH_PORTH: begin
          state_next.port_high_byte = data_byte;
          state_next.phase          = PH_PORTL;
        end
        PH_PORTL: begin
          state_next.port_value = {state.port_high_byte, data_byte};
          status = (state.kind == KIND_NAME) ? ST_NAME : ST_IP;
        end
        default: status = ST_REJECT;
      endcase
    end
  end

  always_comb begin
    result.status      = status;
    result.addr_kind   = state_next.kind;
    result.addr_high   = state_next.addr_hi;
    result.addr_low    = state_next.addr_lo;
    result.dst_port    = state_next.port_value;
    result.name_length = state_next.name_len;
    result.name_valid  = nvalid;
    result.name_byte   = nvalid ? data_byte : 8'd0;
    result.name_index  = nindex;
  end

endmodule
`default_nettype wire

// ----- sv/socks5_connect_request_parser_core.sv -----
// SOCKS5 CONNECT request parser: input register, parse step, result register.
//
// req carries one word per request byte (mode 0) or a restart (mode 1).
// Every accepted word yields exactly one word on res: a status (need more,
// reject, done with IP address, done with hostname) together with the
// address kind, the captured address, the port, the hostname length and,
// for hostname bytes, the byte and its position in the name.
// A word accepted on req is held in the input register; its result is loaded
// into the result register once res is free, and res.valid then stays high
// until the result is taken. One word is taken per cycle whenever res is not
// stalled; the parse state updates in the same cycle a word moves from the
// input register to the result register.
// When res is stalled the result register holds, the input register fills,
// and req.ready drops only once both are occupied.
// Synchronous reset empties both registers and returns the parser to the
// version-byte phase with all captured fields zero.
`default_nettype none
module socks5_connect_request_parser_core
  import socks5p_pkg::*;
(
  input  logic clk,
  input  logic rst,
  socks5p_req_if.sink   req,
  socks5p_res_if.source res
);

  logic          s1_valid;
  logic          s1_mode;
  logic [7:0]    s1_byte;
  logic          out_valid;
  parse_result_t out_res;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  logic          out_free;
  logic          s1_go;

  socks5p_step u_step (
    .state      (state),
    .mode       (s1_mode),
    .data_byte  (s1_byte),
    .state_next (state_next),
    .result     (step_res)
  );

  assign out_free  = !out_valid || res.ready;
  assign s1_go     = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (req.ready) s1_valid <= req.valid;
      if (out_free) out_valid <= s1_valid;
      if (s1_go) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode <= req.mode;
      s1_byte <= req.data_byte;
    end
    if (s1_go) out_res <= step_res;
  end

  assign res.valid       = out_valid;
  assign res.status      = out_res.status;
  assign res.addr_kind   = out_res.addr_kind;
  assign res.addr_high   = out_res.addr_high;
  assign res.addr_low    = out_res.addr_low;
  assign res.dst_port    = out_res.dst_port;
  assign res.name_length = out_res.name_length;
  assign res.name_valid  = out_res.name_valid;
  assign res.name_byte   = out_res.name_byte;
  assign res.name_index  = out_res.name_index;

endmodule
`default_nettype wire

// ----- bench/tb_socks5_connect_request_parser_core.sv -----
// Self-checking bench for the SOCKS5 CONNECT request parser core.
`default_nettype none
module tb_socks5_connect_request_parser_core
  import socks5p_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 850;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    logic       m;
    logic [7:0] d;
    bit         typed;
    status_t    st;
    kind_t      knd;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  socks5p_req_if req_ch ();
  socks5p_res_if res_ch ();

  socks5_connect_request_parser_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state mirror
  phase_t      ph    = PH_VER;
  logic [7:0]  left  = '0;
  logic [1:0]  knd   = '0;
  logic [63:0] ahi   = '0;
  logic [63:0] alo   = '0;
  logic [7:0]  porth = '0;
  logic [15:0] portv = '0;
  logic [7:0]  nlen  = '0;

  parse_result_t parse_q[$];
  int  n_sent    = 0;
  int  errs      = 0;
  int  src_idle  = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  int  quiet     = 0;
  bit  hold_req  = 1'b0;
  bit  hold_done = 1'b0;

  int SRC_IDLE [4] = '{0, 49, 0, 34};
  int SNK_STALL[4] = '{0, 0, 49, 34};

  dir_row_t dir_tab [27] = '{
    '{1'b1, 8'h00,       1'b1, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hFF,       1'b1, ST_REJECT, KIND_IPV4},
    '{1'b0, VER_SOCKS5,  1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h02,       1'b1, ST_REJECT, KIND_IPV4},
    '{1'b0, CMD_CONNECT, 1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hFF,       1'b1, ST_REJECT, KIND_IPV4},
    '{1'b0, 8'h00,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h02,       1'b1, ST_REJECT, KIND_IPV4},
    '{1'b0, TYPE_NAME,   1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h00,       1'b1, ST_REJECT, KIND_NAME},
    '{1'b0, 8'h01,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hFF,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hFF,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hFF,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h00,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h7E,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b1, 8'hFF,       1'b1, ST_MORE,   KIND_IPV4},
    '{1'b0, VER_SOCKS5,  1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, CMD_CONNECT, 1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h00,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, TYPE_IPV4,   1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hFF,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h00,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'hA5,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h5A,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h00,       1'b0, ST_MORE,   KIND_IPV4},
    '{1'b0, 8'h50,       1'b0, ST_MORE,   KIND_IPV4}
  };

  function automatic parse_result_t parse_step(logic m, logic [7:0] b);
    parse_result_t r;
    status_t       st;
    logic          counted;
    logic [7:0]    idx;
    r       = '0;
    st      = ST_MORE;
    counted = 1'b0;
    if (m) begin
      ph    = PH_VER;
      left  = '0;
      knd   = '0;
      ahi   = '0;
      alo   = '0;
      porth = '0;
      portv = '0;
      nlen  = '0;
    end else begin
      case (ph)
        PH_VER: begin
          if (b != VER_SOCKS5) st = ST_REJECT;
          else ph = PH_CMD;
        end
        PH_CMD: begin
          if (b != CMD_CONNECT) st = ST_REJECT;
          else ph = PH_RSV;
        end
        PH_RSV: begin
          if (b != 8'h00) st = ST_REJECT;
          else ph = PH_TYPE;
        end
        PH_TYPE: begin
          if (b == TYPE_IPV4) begin
            knd  = KIND_IPV4;
            left = IPV4_BYTES;
            ahi  = '0;
            alo  = '0;
            ph   = PH_IPV4;
          end else if (b == TYPE_IPV6) begin
            knd  = KIND_IPV6;
            left = IPV6_BYTES;
            ahi  = '0;
            alo  = '0;
            ph   = PH_IPV6;
          end else if (b == TYPE_NAME) begin
            knd = KIND_NAME;
            ph  = PH_NLEN;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_IPV4: begin
          alo     = {32'd0, alo[23:0], b};
          counted = 1'b1;
        end
        PH_IPV6: begin
          idx = IPV6_BYTES - left;
          if (idx < IPV6_HALF) ahi = {ahi[55:0], b};
          else alo = {alo[55:0], b};
          counted = 1'b1;
        end
        PH_NLEN: begin
          if (b == 8'h00) begin
            st = ST_REJECT;
          end else begin
            nlen = b;
            left = b;
            ph   = PH_NAME;
          end
        end
        PH_NAME: begin
          r.name_valid = 1'b1;
          r.name_byte  = b;
          r.name_index = nlen - left;
          counted      = 1'b1;
        end
        PH_PORTH: begin
          porth = b;
          ph    = PH_PORTL;
        end
        PH_PORTL: begin
          portv = {porth, b};
          st    = (knd == KIND_NAME) ? ST_NAME : ST_IP;
        end
        default: st = ST_REJECT;
      endcase
      if (counted) begin
        if (left <= 8'd1) begin
          left = '0;
          ph   = PH_PORTH;
        end else begin
          left = left - 8'd1;
        end
      end
    end
    r.status      = st;
    r.addr_kind   = knd;
    r.addr_high   = ahi;
    r.addr_low    = alo;
    r.dst_port    = portv;
    r.name_length = nlen;
    return r;
  endfunction

  task automatic put_word(input logic m, input logic [7:0] d,
                          input bit typed = 1'b0, input parse_result_t want = '0);
    parse_result_t pred;
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= m;
    req_ch.data_byte <= d;
    do @(posedge clk); while (!req_ch.ready);
    pred = parse_step(m, d);
    parse_q.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // restart, then mostly well-formed requests with occasional bad or cut-short bytes
  task automatic send_request();
    int         pick;
    int         full;
    int         n;
    logic [7:0] t;
    put_word(1'b1, 8'($urandom));
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 8)) put_word($urandom_range(9) == 0, 8'($urandom));
      return;
    end
    if ($urandom_range(24) == 0) put_word(1'b0, 8'($urandom));
    put_word(1'b0, VER_SOCKS5);
    if ($urandom_range(24) == 0) put_word(1'b0, 8'($urandom));
    put_word(1'b0, CMD_CONNECT);
    if ($urandom_range(24) == 0) put_word(1'b0, 8'($urandom));
    put_word(1'b0, 8'h00);
    if ($urandom_range(19) == 0) put_word(1'b0, 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 40) t = TYPE_IPV4;
    else if (pick < 70) t = TYPE_IPV6;
    else t = TYPE_NAME;
    put_word(1'b0, t);
    if (t == TYPE_NAME) begin
      if ($urandom_range(14) == 0) put_word(1'b0, 8'h00);
      if ($urandom_range(29) != 0) full = $urandom_range(1, 12);
      else if ($urandom_range(3) == 0) full = 255;
      else full = $urandom_range(13, 255);
      put_word(1'b0, 8'(full));
    end else begin
      full = (t == TYPE_IPV4) ? IPV4_BYTES : IPV6_BYTES;
    end
    n = ($urandom_range(19) == 0) ? $urandom_range(0, full - 1) : full;
    repeat (n) put_word(1'b0, 8'($urandom));
    if (n < full) return;
    repeat ($urandom_range(2, 4)) put_word(1'b0, 8'($urandom));
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] want,
                           input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : res_side
    parse_result_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (parse_q.size() == 0) begin
        $error("result word with nothing expected");
        errs++;
      end else begin
        w = parse_q.pop_front();
        cmp_field("status",      w.status,      res_ch.status);
        cmp_field("addr_kind",   w.addr_kind,   res_ch.addr_kind);
        cmp_field("addr_high",   w.addr_high,   res_ch.addr_high);
        cmp_field("addr_low",    w.addr_low,    res_ch.addr_low);
        cmp_field("dst_port",    w.dst_port,    res_ch.dst_port);
        cmp_field("name_length", w.name_length, res_ch.name_length);
        cmp_field("name_valid",  w.name_valid,  res_ch.name_valid);
        cmp_field("name_byte",   w.name_byte,   res_ch.name_byte);
        cmp_field("name_index",  w.name_index,  res_ch.name_index);
      end
    end
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_socks5_connect_request_parser_core failed");
      $finish;
    end
  end

  initial begin : stim
    parse_result_t w;
    int            goal;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= 1'b0;
    req_ch.data_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      w           = '0;
      w.status    = dir_tab[i].st;
      w.addr_kind = dir_tab[i].knd;
      put_word(dir_tab[i].m, dir_tab[i].d, dir_tab[i].typed, w);
    end
    for (int p = 0; p < 4; p++) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while (parse_q.size() != 0);
      src_idle  = SRC_IDLE[p];
      stall_pct = SNK_STALL[p];
      if (p == 0) hold_req = 1'b1;
      goal = n_sent + RAND_ITEMS / 4;
      while (n_sent < goal) send_request();
    end
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (parse_q.size() != 0);
    repeat (8) @(posedge clk);
    if (errs == 0) begin
      $display("tb_socks5_connect_request_parser_core passed");
    end else begin
      $display("tb_socks5_connect_request_parser_core failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
